// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the fmq core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is held
`define FMQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check, also active during reset
`define FMQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FMQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define FMQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/fmq_pkg.sv =====
// Types and constants of the FFT magnitude quantizer.
package fmq_pkg;
    localparam int OUT_W   = 33;
    localparam int LVL_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_SH = 16;
    localparam int BOUND_SH = 8;
    localparam int LH_W    = CFG_W + BOUND_SH;
    // quotient bound when the squared sum does not wrap: level * 257 < 2^25
    localparam int QS_W    = LVL_W + 9;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_MIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_MAX     = 2'd2;

    localparam logic [CFG_W-1:0] RST_LEVEL_COUNT = 16'd16;
    localparam logic [CFG_W-1:0] RST_MAG_MIN     = 16'd0;
    localparam logic [CFG_W-1:0] RST_MAG_MAX     = 16'd46341;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_ONE,
        SEL_DIV
    } t_lvl_sel;
endpackage

// ===== rtl/core/fmq_in_if.sv =====
// Input channel: one complex coefficient per item.
interface fmq_in_if #(
    parameter int COMPONENT_BITS = 16
) ();
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] real_part;
    logic signed [COMPONENT_BITS-1:0] imag_part;

    modport source(output valid, real_part, imag_part, input ready);
    modport sink(input valid, real_part, imag_part, output ready);
endinterface

// ===== rtl/core/fmq_out_if.sv =====
// Output channel: quantized coefficient and its level.
interface fmq_out_if import fmq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] out_real;
    logic signed [OUT_W-1:0] out_imag;
    logic [LVL_W-1:0]        quant_level;

    modport source(output valid, out_real, out_imag, quant_level, input ready);
    modport sink(input valid, out_real, out_imag, quant_level, output ready);
endinterface

// ===== rtl/core/fmq_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module fmq_isqrt #(
    parameter int X_W  = 49,
    parameter int SB_W = 34
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_v,
    input  logic [X_W-1:0]           i_x,
    input  logic [SB_W-1:0]          i_sb,
    output logic                     o_v,
    output logic [(X_W+1)/2-1:0]     o_root,
    output logic [SB_W-1:0]          o_sb
);
    localparam int R_W   = (X_W + 1) / 2;
    localparam int XP_W  = 2 * R_W;
    localparam int REM_W = R_W + 3;

    logic             r_v    [R_W];
    logic [XP_W-1:0]  r_x    [R_W];
    logic [REM_W-1:0] r_rem  [R_W];
    logic [R_W-1:0]   r_root [R_W];
    logic [SB_W-1:0]  r_sb   [R_W];

    for (genvar k = 0; k < R_W; k++) begin : g_step
        logic             p_v;
        logic [XP_W-1:0]  p_x;
        logic [REM_W-1:0] p_rem;
        logic [R_W-1:0]   p_root;
        logic [SB_W-1:0]  p_sb;
        logic [REM_W-1:0] w_r;
        logic [REM_W-1:0] w_trial;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign p_v    = i_v;
            assign p_x    = XP_W'(i_x);
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_sb   = i_sb;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_x    = r_x[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_sb   = r_sb[k-1];
        end

        always_comb begin
            w_r     = {p_rem[REM_W-3:0], p_x[XP_W-1 -: 2]};
            w_trial = REM_W'({p_root, 2'b01});
            w_ge    = (w_r >= w_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= {p_x[XP_W-3:0], 2'b00};
                r_rem[k]  <= w_ge ? (w_r - w_trial) : w_r;
                r_root[k] <= {p_root[R_W-2:0], w_ge};
                r_sb[k]   <= p_sb;
            end
        end
    end

    assign o_v    = r_v[R_W-1];
    assign o_root = r_root[R_W-1];
    assign o_sb   = r_sb[R_W-1];
endmodule

// ===== rtl/core/fmq_divu.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage.
module fmq_divu #(
    parameter int N_W  = 40,
    parameter int D_W  = 24,
    parameter int Q_W  = 16,
    parameter int SB_W = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_v,
    input  logic [N_W-1:0]  i_n,
    input  logic [D_W-1:0]  i_d,
    input  logic [SB_W-1:0] i_sb,
    output logic            o_v,
    output logic [Q_W-1:0]  o_q,
    output logic [SB_W-1:0] o_sb
);
    localparam int X_W = N_W + D_W;

    logic            r_v   [Q_W];
    logic [N_W-1:0]  r_rem [Q_W];
    logic [D_W-1:0]  r_d   [Q_W];
    logic [Q_W-1:0]  r_q   [Q_W];
    logic [SB_W-1:0] r_sb  [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        localparam int BIT = Q_W - 1 - k;
        logic            p_v;
        logic [N_W-1:0]  p_rem;
        logic [D_W-1:0]  p_d;
        logic [Q_W-1:0]  p_q;
        logic [SB_W-1:0] p_sb;
        logic [X_W-1:0]  w_nx;
        logic [X_W-1:0]  w_dx;
        logic            w_ge;
        logic [Q_W-1:0]  w_q;

        if (k == 0) begin : g_first
            assign p_v   = i_v;
            assign p_rem = i_n;
            assign p_d   = i_d;
            assign p_q   = '0;
            assign p_sb  = i_sb;
        end else begin : g_next
            assign p_v   = r_v[k-1];
            assign p_rem = r_rem[k-1];
            assign p_d   = r_d[k-1];
            assign p_q   = r_q[k-1];
            assign p_sb  = r_sb[k-1];
        end

        always_comb begin
            w_nx     = X_W'(p_rem);
            w_dx     = X_W'(p_d) << BIT;
            w_ge     = (w_nx >= w_dx);
            w_q      = p_q;
            w_q[BIT] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? N_W'(w_nx - w_dx) : p_rem;
                r_d[k]   <= p_d;
                r_q[k]   <= w_q;
                r_sb[k]  <= p_sb;
            end
        end
    end

    assign o_v  = r_v[Q_W-1];
    assign o_q  = r_q[Q_W-1];
    assign o_sb = r_sb[Q_W-1];
endmodule

// ===== rtl/core/fft_magnitude_quantize.sv =====
// FFT magnitude quantizer top level: magnitude, level and phase-keeping rescale.
// Stages in order: register A, the bit-per-stage square root, register B, the
// restoring level divider, register C, the two rescale dividers and output register D.
// Throughput: one item per cycle; a stall at the output freezes the whole pipe.
// Reset (synchronous, active low) empties the pipe and loads register defaults.
`include "assert_macros.svh"
module fft_magnitude_quantize import fmq_pkg::*; #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fmq_in_if.sink               i_coef,
    fmq_out_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    localparam int CB     = COMPONENT_BITS;
    localparam int S_W    = 2 * CB + 1 + FRAC_SH;
    localparam bit WRAP   = (S_W > 64);
    localparam int SQ_W   = WRAP ? 64 : S_W;
    localparam int MAG_W  = (SQ_W + 1) / 2;
    localparam int CMP_W  = MAG_W + LH_W;
    localparam int PN_W   = MAG_W + LVL_W;
    localparam int PR_W   = LVL_W + CB;
    localparam int NUM_W  = PR_W + FRAC_SH;
    localparam int Q_W    = WRAP ? NUM_W : QS_W;
    localparam int SB1_W  = 2 * CB + 2;
    localparam int SB2_W  = 2 + MAG_W + SB1_W;
    localparam int SB3_W  = 2 + LVL_W;

    logic [CFG_W-1:0] r_level_count;
    logic [CFG_W-1:0] r_mag_min;
    logic [CFG_W-1:0] r_mag_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count <= RST_LEVEL_COUNT;
            r_mag_min     <= RST_MAG_MIN;
            r_mag_max     <= RST_MAG_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEVEL_COUNT: r_level_count <= i_cfg_data;
                CFG_MAG_MIN:     r_mag_min     <= i_cfg_data;
                CFG_MAG_MAX:     r_mag_max     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    logic w_en;
    logic r_out_v;

    assign w_en         = !r_out_v || o_res.ready;
    assign i_coef.ready = w_en;

    // stage A: magnitudes of components and scaled squared sum
    logic [CB-1:0]     w_re_u, w_im_u, w_re_abs, w_im_abs;
    logic [2*CB-1:0]   w_p_re, w_p_im;
    logic [2*CB:0]     w_sum;
    logic              r_a_v;
    logic [SQ_W-1:0]   r_a_sq;
    logic [SB1_W-1:0]  r_a_sb;

    always_comb begin
        w_re_u   = i_coef.real_part;
        w_im_u   = i_coef.imag_part;
        w_re_abs = w_re_u[CB-1] ? (~w_re_u + 1'b1) : w_re_u;
        w_im_abs = w_im_u[CB-1] ? (~w_im_u + 1'b1) : w_im_u;
        w_p_re   = w_re_abs * w_re_abs;
        w_p_im   = w_im_abs * w_im_abs;
        w_sum    = {1'b0, w_p_re} + {1'b0, w_p_im};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_coef.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_sq <= SQ_W'({w_sum, FRAC_SH'(0)});
            r_a_sb <= {w_re_u[CB-1], w_im_u[CB-1], w_re_abs, w_im_abs};
        end
    end

    // square root
    logic             w_s_v;
    logic [MAG_W-1:0] w_s_mag;
    logic [SB1_W-1:0] w_s_sb;

    fmq_isqrt #(.X_W(SQ_W), .SB_W(SB1_W)) u_isqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_v    (r_a_v),
        .i_x    (r_a_sq),
        .i_sb   (r_a_sb),
        .o_v    (w_s_v),
        .o_root (w_s_mag),
        .o_sb   (w_s_sb)
    );

    // stage B: level range decision and level numerator
    logic [CMP_W-1:0] w_mx, w_lx, w_hx;
    logic [MAG_W-1:0] w_diff;
    t_lvl_sel         w_sel;
    logic             r_b_v;
    logic [PN_W-1:0]  r_b_num;
    logic [LH_W-1:0]  r_b_den;
    logic [SB2_W-1:0] r_b_sb;

    always_comb begin
        w_mx   = CMP_W'(w_s_mag);
        w_lx   = CMP_W'({r_mag_min, BOUND_SH'(0)});
        w_hx   = CMP_W'({r_mag_max, BOUND_SH'(0)});
        w_diff = MAG_W'(w_mx - w_lx);
        if (w_mx < w_lx) begin
            w_sel = SEL_ZERO;
        end else if (w_mx > w_hx) begin
            w_sel = SEL_ONE;
        end else if (r_mag_max <= r_mag_min) begin
            w_sel = SEL_ZERO;
        end else begin
            w_sel = SEL_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_en) begin
            r_b_v <= w_s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_num <= w_diff * r_level_count;
            r_b_den <= {r_mag_max, BOUND_SH'(0)} - {r_mag_min, BOUND_SH'(0)};
            r_b_sb  <= {w_sel, w_s_mag, w_s_sb};
        end
    end

    // level divider
    logic             w_l_v;
    logic [LVL_W-1:0] w_l_q;
    logic [SB2_W-1:0] w_l_sb;

    fmq_divu #(.N_W(PN_W), .D_W(LH_W), .Q_W(LVL_W), .SB_W(SB2_W)) u_lvl_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_v    (r_b_v),
        .i_n    (r_b_num),
        .i_d    (r_b_den),
        .i_sb   (r_b_sb),
        .o_v    (w_l_v),
        .o_q    (w_l_q),
        .o_sb   (w_l_sb)
    );

    // stage C: level select and level times component
    t_lvl_sel         w_l_sel;
    logic [MAG_W-1:0] w_l_mag;
    logic             w_l_sr, w_l_si;
    logic [CB-1:0]    w_l_re, w_l_im;
    logic [LVL_W-1:0] w_lvl;
    logic             r_c_v;
    logic [PR_W-1:0]  r_c_pr, r_c_pi;
    logic [MAG_W-1:0] r_c_mag;
    logic             r_c_sr, r_c_si;
    logic [LVL_W-1:0] r_c_lvl;

    always_comb begin
        {w_l_sel, w_l_mag, w_l_sr, w_l_si, w_l_re, w_l_im} = w_l_sb;
        unique case (w_l_sel)
            SEL_ZERO: w_lvl = '0;
            SEL_ONE:  w_lvl = LVL_W'(1);
            SEL_DIV:  w_lvl = w_l_q;
            default:  w_lvl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_en) begin
            r_c_v <= w_l_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_pr  <= w_lvl * w_l_re;
            r_c_pi  <= w_lvl * w_l_im;
            r_c_mag <= w_l_mag;
            r_c_sr  <= w_l_sr;
            r_c_si  <= w_l_si;
            r_c_lvl <= w_lvl;
        end
    end

    // rescale dividers
    logic             w_dv, w_dv_im;
    logic [Q_W-1:0]   w_q_re, w_q_im;
    logic [SB3_W-1:0] w_d_sb;
    logic             w_d_si;

    fmq_divu #(.N_W(NUM_W), .D_W(MAG_W), .Q_W(Q_W), .SB_W(SB3_W)) u_re_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_v    (r_c_v),
        .i_n    ({r_c_pr, FRAC_SH'(0)}),
        .i_d    (r_c_mag),
        .i_sb   ({r_c_sr, r_c_mag == '0, r_c_lvl}),
        .o_v    (w_dv),
        .o_q    (w_q_re),
        .o_sb   (w_d_sb)
    );

    fmq_divu #(.N_W(NUM_W), .D_W(MAG_W), .Q_W(Q_W), .SB_W(1)) u_im_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_v    (r_c_v),
        .i_n    ({r_c_pi, FRAC_SH'(0)}),
        .i_d    (r_c_mag),
        .i_sb   (r_c_si),
        .o_v    (w_dv_im),
        .o_q    (w_q_im),
        .o_sb   (w_d_si)
    );

    // stage D: sign, zero magnitude, output register
    logic [OUT_W+Q_W-1:0] w_ext_re, w_ext_im;
    logic [OUT_W-1:0]     w_mre, w_mim;
    logic                 w_d_sr, w_d_zero;
    logic [LVL_W-1:0]     w_d_lvl;
    logic [OUT_W-1:0]     n_out_re, n_out_im;
    logic [OUT_W-1:0]     r_out_re, r_out_im;
    logic [LVL_W-1:0]     r_out_lvl;

    always_comb begin
        {w_d_sr, w_d_zero, w_d_lvl} = w_d_sb;
        w_ext_re = {OUT_W'(0), w_q_re};
        w_ext_im = {OUT_W'(0), w_q_im};
        w_mre    = w_ext_re[OUT_W-1:0];
        w_mim    = w_ext_im[OUT_W-1:0];
        n_out_re = w_d_zero ? '0 : (w_d_sr ? (OUT_W'(0) - w_mre) : w_mre);
        n_out_im = w_d_zero ? '0 : (w_d_si ? (OUT_W'(0) - w_mim) : w_mim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_dv && w_dv_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_re  <= n_out_re;
            r_out_im  <= n_out_im;
            r_out_lvl <= w_d_lvl;
        end
    end

    assign o_res.valid       = r_out_v;
    assign o_res.out_real    = r_out_re;
    assign o_res.out_imag    = r_out_im;
    assign o_res.quant_level = r_out_lvl;

    `FMQ_ASSERT(a_zero_level, i_clk, i_rst_n, (o_res.valid && o_res.quant_level == '0) |-> (o_res.out_real == '0 && o_res.out_imag == '0), "level zero item has nonzero components")
    `FMQ_ASSERT(a_stall_hold, i_clk, i_rst_n, !w_en |=> $stable(w_dv), "pipe moved during a stall")
    `FMQ_ASSERT(a_lanes_align, i_clk, i_rst_n, w_dv == w_dv_im, "rescale lanes out of step")
    `FMQ_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !r_out_v, "output valid after reset")
endmodule

// ===== dv/fft_magnitude_quantize_test.sv =====
// Self-checking testbench for the FFT magnitude quantizer: directed and random coefficients.
module fft_magnitude_quantize_test;
    import fmq_pkg::*;

    localparam int CB = 16;
    localparam int DRAIN_CYCLES = 90;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [OUT_W-1:0] re;
        logic [OUT_W-1:0] im;
        logic [LVL_W-1:0] lvl;
    } t_quant;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    fmq_in_if #(.COMPONENT_BITS(CB)) cin ();
    fmq_out_if cout ();

    fft_magnitude_quantize #(.COMPONENT_BITS(CB)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_coef(cin),
        .o_res(cout),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    t_quant expected_q[$];
    int mismatches = 0;
    int cycles = 0;
    int burst_left = 0;
    longint unsigned steps, lo_bound, hi_bound;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v >>= 2;
        while (bit_v != 0) begin
            if (x >= res + bit_v) begin
                x -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic logic [OUT_W-1:0] rescale(longint unsigned lvl, longint unsigned mag,
                                                 bit neg, longint unsigned mag_q);
        longint unsigned q;
        q = (lvl * mag * 64'd65536) / mag_q;
        if (neg) q = 64'd0 - q;
        return q[OUT_W-1:0];
    endfunction

    function automatic t_quant quantize(logic signed [CB-1:0] re, logic signed [CB-1:0] im);
        t_quant r;
        longint sr, si;
        longint unsigned ar, ai, mag_q, lvl;
        bit rneg, ineg;
        sr = re;
        si = im;
        rneg = sr < 0;
        ineg = si < 0;
        ar = rneg ? -sr : sr;
        ai = ineg ? -si : si;
        mag_q = int_sqrt((ar * ar + ai * ai) * 64'd65536);
        if (mag_q < lo_bound) lvl = 0;
        else if (mag_q > hi_bound) lvl = 1;
        else if (hi_bound <= lo_bound) lvl = 0;
        else lvl = ((mag_q - lo_bound) * steps) / (hi_bound - lo_bound);
        lvl &= 64'hFFFF;
        if (mag_q == 0) begin
            r.re = '0;
            r.im = '0;
        end else begin
            r.re = rescale(lvl, ar, rneg, mag_q);
            r.im = rescale(lvl, ai, ineg, mag_q);
        end
        r.lvl = lvl[LVL_W-1:0];
        return r;
    endfunction

    // shadow registers, prediction and result check
    always @(posedge i_clk) begin
        t_quant e;
        cycles++;
        if (!i_rst_n) begin
            steps <= RST_LEVEL_COUNT;
            lo_bound <= 64'(RST_MAG_MIN) * 256;
            hi_bound <= 64'(RST_MAG_MAX) * 256;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEVEL_COUNT: steps <= i_cfg_data;
                    CFG_MAG_MIN: lo_bound <= 64'(i_cfg_data) * 256;
                    CFG_MAG_MAX: hi_bound <= 64'(i_cfg_data) * 256;
                    default: ;
                endcase
            end
            if (cin.valid && cin.ready) expected_q.push_back(quantize(cin.real_part, cin.imag_part));
            if (cout.valid && cout.ready) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result item");
                end else begin
                    e = expected_q.pop_front();
                    if (e.re !== cout.out_real || e.im !== cout.out_imag
                            || e.lvl !== cout.quant_level) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h %h %0d got %h %h %0d", e.re, e.im,
                                     e.lvl, cout.out_real, cout.out_imag, cout.quant_level);
                    end
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("** fft_magnitude_quantize: FAILED **");
            $finish;
        end
    end

    // receiver stall pattern: the mode is chosen by bits 9:8 of the cycle counter
    always @(negedge i_clk) begin
        case (cycles[9:8])
            2'd0: cout.ready <= 1'b1;
            2'd1: cout.ready <= ($urandom_range(0, 9) < 7);
            2'd2: cout.ready <= cycles[2];
            default: cout.ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic send_coef(logic signed [CB-1:0] re, logic signed [CB-1:0] im);
        if (burst_left == 0) begin
            cin.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        cin.valid <= 1'b1;
        cin.real_part <= re;
        cin.imag_part <= im;
        do @(posedge i_clk); while (!cin.ready);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic drain();
        cin.valid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(logic [CFG_W-1:0] n, logic [CFG_W-1:0] mn, logic [CFG_W-1:0] mx);
        cfg_write(CFG_LEVEL_COUNT, n);
        cfg_write(CFG_MAG_MIN, mn);
        cfg_write(CFG_MAG_MAX, mx);
    endtask

    task automatic send_corners();
        send_coef(16'sd0, 16'sd0);
        send_coef(16'sd32767, 16'sd0);
        send_coef(-16'sd32768, 16'sd0);
        send_coef(16'sd0, -16'sd32768);
        send_coef(-16'sd32768, -16'sd32768);
        send_coef(16'sd32767, 16'sd32767);
        send_coef(-16'sd32768, 16'sd32767);
        send_coef(16'sd1, 16'sd0);
        send_coef(-16'sd1, -16'sd1);
        send_coef(16'sd300, -16'sd400);
        send_coef(16'sh5555, -16'sh2aab);
    endtask

    task automatic test_reset_defaults();
        send_corners();
        drain();
    endtask

    task automatic test_config_extremes();
        set_config(16'd65535, 16'd0, 16'd65535);
        send_corners();
        drain();
        set_config(16'd1, 16'd100, 16'd200);   // above maximum and below minimum
        send_coef(16'sd50, 16'sd0);
        send_coef(16'sd150, -16'sd10);
        send_coef(16'sd200, 16'sd0);
        send_coef(-16'sd30000, 16'sd5);
        drain();
        set_config(16'd0, 16'd10, 16'd500);    // zero level count
        send_coef(16'sd100, 16'sd100);
        drain();
        set_config(16'd40, 16'd300, 16'd300);  // empty range
        send_coef(16'sd300, 16'sd0);
        send_coef(16'sd0, -16'sd300);
        drain();
        set_config(16'd65535, 16'd65535, 16'd0);
        send_coef(-16'sd32768, -16'sd32768);
        drain();
    endtask

    task automatic test_random();
        int mn, mx, amp;
        for (int phase = 0; phase < 10; phase++) begin
            mn = $urandom_range(0, 20000);
            mx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, mn) : $urandom_range(mn, 46341);
            set_config(CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(1, 300)),
                       CFG_W'(mn), CFG_W'(mx));
            for (int k = 0; k < 65; k++) begin
                amp = ($urandom_range(0, 2) == 0) ? 32767 : $urandom_range(1, mx + 10);
                if (amp > 32767) amp = 32767;
                if ($urandom_range(0, 4) == 0)
                    send_coef($signed(CB'($urandom)), $signed(CB'($urandom)));
                else
                    send_coef($signed(CB'($urandom_range(0, 2 * amp) - amp)),
                              $signed(CB'($urandom_range(0, 2 * amp) - amp)));
            end
            drain();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_LEVEL_COUNT;
        i_cfg_data = '0;
        cin.valid = 1'b0;
        cin.real_part = '0;
        cin.imag_part = '0;
        cout.ready = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_config_extremes();
        test_random();
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("** fft_magnitude_quantize: PASSED **");
        end else begin
            $display("** fft_magnitude_quantize: FAILED **");
        end
        $finish;
    end
endmodule

// ===== fft_magnitude_quantize.f =====
+incdir+rtl/core
rtl/core/fmq_pkg.sv
rtl/core/fmq_in_if.sv
rtl/core/fmq_out_if.sv
rtl/core/fmq_isqrt.sv
rtl/core/fmq_divu.sv
rtl/core/fft_magnitude_quantize.sv
dv/fft_magnitude_quantize_test.sv
